// ----- src/rmssd_hrv_pkg.sv -----
// ----------------------------------------------------------------------------
// RMSSD HRV package
// Shared widths, constants and state type for the RMSSD heart-rate-variability
// unit.
// ----------------------------------------------------------------------------
package rmssd_hrv_pkg;

   // default cap on intervals per set
   localparam int MAX_INTERVALS_DEF = 32;

   // field widths
   localparam int IV_W   = 12;
   localparam int Q4_W   = 16;
   localparam int USED_W = 6;

   // accumulator and square widths
   localparam int SQ_W  = 2 * IV_W;
   localparam int SUM_W = 30;
   localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

   // radicand is the mean scaled by 256, root is half its width
   localparam int RAD_W  = SUM_W + 8;
   localparam int ROOT_W = RAD_W / 2;

   // shared subtractor width, covers the square-root remainder
   localparam int ALU_W = 24;

   // iteration counts of the shared unit
   localparam int DIV_STEPS  = SUM_W;
   localparam int SQRT_STEPS = ROOT_W;
   localparam int STEP_W     = 5;

   // result when fewer than two intervals arrived: 45 ms in 1/16 ms
   localparam logic [Q4_W-1:0] DEFAULT_Q4 = 16'd720;
   localparam logic [Q4_W-1:0] Q4_MAX     = {Q4_W{1'b1}};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_ACCUM,
      ST_DIVIDE,
      ST_SQRT,
      ST_DONE
   } state_type;

endpackage

// ----- src/rmssd_heart_rate_variability_unit.sv -----
// ----------------------------------------------------------------------------
// RMSSD heart-rate-variability unit
// Accumulates squared successive interval differences and, on the last
// interval of a set, returns the root mean square in 1/16 ms.
// ----------------------------------------------------------------------------
// Usage:
//   A request (req_interval_ms, req_last_of_set) is taken on a rising edge
//   with start high and busy low. Only the first MAX_INTERVALS intervals of
//   a set enter the sum; later ones are dropped, but a marked request still
//   closes the set.
//   An unmarked request keeps busy high through the square and accumulate
//   states. A marked request with at least two intervals keeps busy high
//   through square, accumulate, a 30-step restoring divide and a 19-step
//   square root, both one bit per cycle on one shared 24-bit subtractor,
//   then the done state with the result on the rsp_ ports. With fewer than two
//   intervals the result (720, used_default) comes in the done state right after accumulate.
//   rsp_valid is high for exactly one cycle per result; the receiver cannot
//   stall and the result is taken in that cycle.
//   Synchronous reset returns to idle and clears the count, the previous
//   interval and the running sum; a set in progress is lost.
// ----------------------------------------------------------------------------
module rmssd_heart_rate_variability_unit
   import rmssd_hrv_pkg::*;
#(
   parameter int MAX_INTERVALS = MAX_INTERVALS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [IV_W-1:0]   req_interval_ms,
   input  logic              req_last_of_set,
   output logic              rsp_valid,
   output logic [Q4_W-1:0]   rsp_rmssd_q4,
   output logic              rsp_used_default,
   output logic [USED_W-1:0] rsp_intervals_used
);

   localparam int CNT_W = $clog2(MAX_INTERVALS + 1);

   state_type           state_ff, state_in;
   logic [IV_W-1:0]     iv_ff, iv_in;
   logic                last_ff, last_in;
   logic [IV_W-1:0]     prev_ff, prev_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [SQ_W-1:0]     sq_ff, sq_in;
   logic                take_ff, take_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [ALU_W-1:0]    rem_ff, rem_in;
   logic [SUM_W-1:0]    quo_ff, quo_in;
   logic [RAD_W-1:0]    rad_ff, rad_in;
   logic [ROOT_W-1:0]   root_ff, root_in;

   logic                accept;
   logic                room;
   logic [IV_W-1:0]     abs_diff;
   logic [SUM_W:0]      sum_wide;
   logic [CNT_W-1:0]    divisor;
   logic [ALU_W-1:0]    alu_a, alu_b;
   logic [ALU_W:0]      alu_diff;
   logic                alu_ge;
   logic                steps_done;

   assign accept     = start && (state_ff == ST_IDLE);
   assign room       = count_ff < CNT_W'(MAX_INTERVALS);
   assign divisor    = count_ff - CNT_W'(1);
   assign abs_diff   = (iv_ff > prev_ff) ? (iv_ff - prev_ff) : (prev_ff - iv_ff);
   assign sum_wide   = {1'b0, sum_ff} + (SUM_W+1)'(sq_ff);

   // shared trial subtractor: divide and square-root steps
   always_comb begin
      case (state_ff)
         ST_DIVIDE: begin
            alu_a = {rem_ff[ALU_W-2:0], quo_ff[SUM_W-1]};
            alu_b = ALU_W'(divisor);
         end
         ST_SQRT: begin
            alu_a = {rem_ff[ALU_W-3:0], rad_ff[RAD_W-1 -: 2]};
            alu_b = ALU_W'({root_ff, 2'b01});
         end
         default: begin
            alu_a = '0;
            alu_b = '0;
         end
      endcase
   end

   assign alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
   assign alu_ge   = !alu_diff[ALU_W];

   // last step of the running iteration
   always_comb begin
      case (state_ff)
         ST_DIVIDE: steps_done = (step_ff == STEP_W'(DIV_STEPS - 1));
         ST_SQRT:   steps_done = (step_ff == STEP_W'(SQRT_STEPS - 1));
         default:   steps_done = 1'b0;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_SQUARE;
         end
         ST_SQUARE: state_in = ST_ACCUM;
         ST_ACCUM: begin
            if (!last_ff) state_in = ST_IDLE;
            else if (count_in < CNT_W'(2)) state_in = ST_DONE;
            else state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (steps_done) state_in = ST_SQRT;
         end
         ST_SQRT: begin
            if (steps_done) state_in = ST_DONE;
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      busy               = (state_ff != ST_IDLE);
      rsp_valid          = (state_ff == ST_DONE);
      rsp_used_default   = (count_ff < CNT_W'(2));
      rsp_intervals_used = USED_W'(count_ff);
      if (rsp_used_default) begin
         rsp_rmssd_q4 = DEFAULT_Q4;
      end else if (root_ff[ROOT_W-1:Q4_W] != '0) begin
         rsp_rmssd_q4 = Q4_MAX;
      end else begin
         rsp_rmssd_q4 = root_ff[Q4_W-1:0];
      end
   end

   // datapath
   always_comb begin
      iv_in   = iv_ff;
      last_in = last_ff;
      prev_in = prev_ff;
      count_in = count_ff;
      sum_in  = sum_ff;
      sq_in   = sq_ff;
      take_in = take_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      rad_in  = rad_ff;
      root_in = root_ff;
      case (state_ff)
         ST_IDLE: begin
            // capture the request
            if (accept) begin
               iv_in   = req_interval_ms;
               last_in = req_last_of_set;
            end
         end
         ST_SQUARE: begin
            // square the difference to the previous interval
            take_in = room;
            sq_in   = (count_ff != '0) ? SQ_W'(abs_diff * abs_diff) : '0;
         end
         ST_ACCUM: begin
            // add with saturation, advance the count
            if (take_ff) begin
               sum_in   = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
               prev_in  = iv_ff;
               count_in = count_ff + CNT_W'(1);
            end
            quo_in  = sum_in;
            rem_in  = '0;
            step_in = '0;
         end
         ST_DIVIDE: begin
            // one quotient bit per cycle
            rem_in  = alu_ge ? alu_diff[ALU_W-1:0] : alu_a;
            quo_in  = {quo_ff[SUM_W-2:0], alu_ge};
            step_in = step_ff + STEP_W'(1);
            if (steps_done) begin
               rad_in  = {quo_in, 8'h00};
               rem_in  = '0;
               root_in = '0;
               step_in = '0;
            end
         end
         ST_SQRT: begin
            // one root bit per cycle
            rem_in  = alu_ge ? alu_diff[ALU_W-1:0] : alu_a;
            root_in = {root_ff[ROOT_W-2:0], alu_ge};
            rad_in  = {rad_ff[RAD_W-3:0], 2'b00};
            step_in = step_ff + STEP_W'(1);
         end
         ST_DONE: begin
            // clear for the next set
            prev_in  = '0;
            count_in = '0;
            sum_in   = '0;
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         prev_ff  <= '0;
         count_ff <= '0;
         sum_ff   <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         prev_ff  <= prev_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
         step_ff  <= step_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      iv_ff   <= iv_in;
      last_ff <= last_in;
      sq_ff   <= sq_in;
      take_ff <= take_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      rad_ff  <= rad_in;
      root_ff <= root_in;
   end

   // a result only appears while busy
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> busy)
      else $error("result strobe outside a busy period");

   // an accepted request makes the block busy
   assert property (@(posedge clock) disable iff (reset) (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   // the strobe lasts one cycle
   assert property (@(posedge clock) disable iff (reset) rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   // the default result carries the default value
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_used_default) |-> (rsp_rmssd_q4 == DEFAULT_Q4))
      else $error("default result with wrong value");

   // the count never passes the cap
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_INTERVALS))
      else $error("interval count above the cap");

endmodule

// ----- tb/rmssd_heart_rate_variability_unit_tb.sv -----
// ----------------------------------------------------------------------------
// RMSSD heart-rate-variability unit testbench
// Sends sets of beat intervals through the start/busy port and predicts the
// RMSSD of each closed set from its own model of the running sum, the count
// and the capped set length. Each result strobe is compared with the oldest
// predicted result. The run covers directed extremes, then random sets of
// varied length and content under several idling patterns.
// ----------------------------------------------------------------------------
module rmssd_heart_rate_variability_unit_tb
   import rmssd_hrv_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RESET_CYCLES = 12;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 60;
   localparam int PHASE_ITEMS  = 300;

   typedef struct {
      logic [Q4_W-1:0]   rmssd_q4;
      logic              used_default;
      logic [USED_W-1:0] intervals_used;
   } rmssd_result_type;

   // Predict the RMSSD of each set and hold the results still to arrive.
   class hrv_scoreboard;
      rmssd_result_type rmssd_due[$];
      logic [IV_W-1:0]  last_interval;
      int unsigned      accepted_count;
      longint unsigned  diff_sq_sum;
      int               errors;

      function new();
         last_interval  = '0;
         accepted_count = 0;
         diff_sq_sum    = 0;
         errors         = 0;
      endfunction

      // Floor square root for roots below 2^17, one result bit at a time from the top.
      function automatic longint unsigned floor_root(longint unsigned v);
         longint unsigned r;
         longint unsigned t;
         r = 0;
         for (int b = 16; b >= 0; b--) begin
            t = r | (longint'(1) << b);
            if (t * t <= v)
               r = t;
         end
         return r;
      endfunction

      function int pending();
         return rmssd_due.size();
      endfunction

      // Fold one accepted request into the set; close the set on the mark.
      function void take_interval(logic [IV_W-1:0] iv, logic last);
         longint unsigned  diff;
         longint unsigned  mean;
         longint unsigned  root;
         rmssd_result_type res;
         if (accepted_count < MAX_INTERVALS_DEF) begin
            if (accepted_count > 0) begin
               diff = (iv > last_interval) ? iv - last_interval : last_interval - iv;
               diff_sq_sum += diff * diff;
               if (diff_sq_sum > SUM_MAX)
                  diff_sq_sum = SUM_MAX;
            end
            last_interval = iv;
            accepted_count++;
         end
         if (last) begin
            if (accepted_count < 2) begin
               res.rmssd_q4     = DEFAULT_Q4;
               res.used_default = 1'b1;
            end else begin
               mean = diff_sq_sum / (accepted_count - 1);
               root = floor_root(mean * 256);
               res.rmssd_q4     = (root > Q4_MAX) ? Q4_MAX : root[Q4_W-1:0];
               res.used_default = 1'b0;
            end
            res.intervals_used = accepted_count[USED_W-1:0];
            rmssd_due.push_back(res);
            last_interval  = '0;
            accepted_count = 0;
            diff_sq_sum    = 0;
         end
      endfunction

      // Compare one result strobe with the oldest prediction.
      function void check_rmssd(logic [Q4_W-1:0] q4, logic dflt, logic [USED_W-1:0] used);
         rmssd_result_type exp_res;
         if (rmssd_due.size() == 0) begin
            $error("result with none expected: rmssd_q4 %0d used_default %0d intervals_used %0d",
                   q4, dflt, used);
            errors++;
            return;
         end
         exp_res = rmssd_due.pop_front();
         if (q4 !== exp_res.rmssd_q4) begin
            $error("rmssd_q4 expected %0d actual %0d", exp_res.rmssd_q4, q4);
            errors++;
         end
         if (dflt !== exp_res.used_default) begin
            $error("used_default expected %0d actual %0d", exp_res.used_default, dflt);
            errors++;
         end
         if (used !== exp_res.intervals_used) begin
            $error("intervals_used expected %0d actual %0d", exp_res.intervals_used, used);
            errors++;
         end
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic [IV_W-1:0]   req_interval_ms;
   logic              req_last_of_set;
   logic              rsp_valid;
   logic [Q4_W-1:0]   rsp_rmssd_q4;
   logic              rsp_used_default;
   logic [USED_W-1:0] rsp_intervals_used;

   hrv_scoreboard sb;
   int            idle_cycles;
   int            items_sent;
   int            sender_idle_pct;

   rmssd_heart_rate_variability_unit u_top (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_interval_ms    (req_interval_ms),
      .req_last_of_set    (req_last_of_set),
      .rsp_valid          (rsp_valid),
      .rsp_rmssd_q4       (rsp_rmssd_q4),
      .rsp_used_default   (rsp_used_default),
      .rsp_intervals_used (rsp_intervals_used)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Note accepted requests, check result strobes, count quiet cycles.
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (start && !busy)
            sb.take_interval(req_interval_ms, req_last_of_set);
         if (rsp_valid)
            sb.check_rmssd(rsp_rmssd_q4, rsp_used_default, rsp_intervals_used);
         idle_cycles <= ((start && !busy) || rsp_valid) ? 0 : idle_cycles + 1;
      end
   end

   // Abort when nothing moves for too long.
   initial begin
      idle_cycles = 0;
      @(negedge reset);
      while (idle_cycles < IDLE_LIMIT)
         @(posedge clock);
      $display("Some tests failed");
      $finish;
   end

   // Drive one request, after an optional idle gap, and hold it until taken.
   task automatic send_request(logic [IV_W-1:0] iv, logic last);
      int gap;
      gap = 0;
      if ($urandom_range(99) < sender_idle_pct)
         gap = ($urandom_range(1) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 60);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start           <= 1'b1;
      req_interval_ms <= iv;
      req_last_of_set <= last;
      do
         @(posedge clock);
      while (busy);
      items_sent++;
   endtask

   // Hold off the sender until every predicted result has arrived.
   task automatic drain_results();
      start <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
   endtask

   // Send one random set: length and interval style chosen per set.
   task automatic send_random_set();
      int len;
      int style;
      int iv;
      int pick;
      pick = $urandom_range(99);
      if (pick < 10)
         len = 1;
      else if (pick < 20)
         len = 2;
      else if (pick < 80)
         len = $urandom_range(3, MAX_INTERVALS_DEF - 1);
      else
         len = $urandom_range(MAX_INTERVALS_DEF, MAX_INTERVALS_DEF + 8);
      style = $urandom_range(2);
      iv    = $urandom_range(500, 1200);
      for (int k = 0; k < len; k++) begin
         case (style)
            0: begin
               // heartbeat-like drift around a resting rate
               iv = iv + $urandom_range(0, 160) - 80;
               if (iv < 0)
                  iv = 0;
               if (iv > 4095)
                  iv = 4095;
            end
            1: iv = $urandom_range(4095);
            default: begin
               pick = $urandom_range(3);
               iv = (pick == 0) ? 0 : (pick == 1) ? 4095 : $urandom_range(4095);
            end
         endcase
         send_request(iv[IV_W-1:0], k == len - 1);
      end
   endtask

   initial begin
      sb              = new();
      items_sent      = 0;
      sender_idle_pct = 0;
      reset           <= 1'b1;
      start           <= 1'b0;
      req_interval_ms <= '0;
      req_last_of_set <= 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed: single-interval sets give the default result.
      send_request(12'd0, 1'b1);
      send_request(12'd4095, 1'b1);
      // Largest and zero differences.
      send_request(12'd0, 1'b0);
      send_request(12'd4095, 1'b1);
      send_request(12'd4095, 1'b0);
      send_request(12'd0, 1'b1);
      send_request(12'd800, 1'b0);
      send_request(12'd800, 1'b1);
      // Alternating extremes over three intervals.
      send_request(12'd0, 1'b0);
      send_request(12'd4095, 1'b0);
      send_request(12'd0, 1'b1);
      // Overlong set: intervals past the cap are dropped, the mark still closes it.
      for (int k = 0; k < MAX_INTERVALS_DEF + 2; k++)
         send_request((k % 2 == 0) ? 12'd4095 : 12'd0, k == MAX_INTERVALS_DEF + 1);

      // Random sets over four phases with three idling patterns.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       sender_idle_pct = 0;
            1:       sender_idle_pct = 57;
            2:       sender_idle_pct = 0;
            default: sender_idle_pct = 24;
         endcase
         items_sent = 0;
         while (items_sent < PHASE_ITEMS)
            send_random_set();
         if (phase == 1)
            drain_results();
      end

      // Wait for outstanding results, then let the block settle.
      start <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
